// ===== hdl/ded_pkg.sv =====
// ----------------------------------------------------------------------------
// ded_pkg
// Shared widths, operation and status codes, and the command type passed
// from the front end to the back end of the double-ended queue.
// ----------------------------------------------------------------------------
package ded_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);
   localparam int FUNC_W        = 3;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_COUNT      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                      valid;
      logic [FUNC_W-1:0]         op;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

// ===== hdl/ded_if.sv =====
// ----------------------------------------------------------------------------
// ded_if
// Request and response channel interfaces of the double-ended queue.
// ----------------------------------------------------------------------------
interface ded_req_if import ded_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface ded_rsp_if import ded_pkg::*; #(parameter int CNT_W = CNT_W_DEFAULT) ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] data;
   logic [CNT_W-1:0]          occupancy;
   logic                      last;

   modport source (output valid, output status, output data, output occupancy,
                   output last, input ready);
   modport sink   (input valid, input status, input data, input occupancy,
                   input last, output ready);
endinterface

// ===== hdl/ded_front.sv =====
// ----------------------------------------------------------------------------
// ded_front
// Accepts requests, drops unknown operation codes, and holds the known ones
// in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module ded_front import ded_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ded_req_if.sink   req,
   output cmd_type   cmd,
   input  logic      cmd_ready
);

   localparam logic [1:0] QUEUE_FULL = 2'd2;

   logic [FUNC_W-1:0]         op_ff    [2];
   logic signed [VALUE_W-1:0] value_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                fill_ff, fill_in;
   logic                      known;
   logic                      push;
   logic                      pop;

   assign known     = (req.func <= FUNC_COUNT);
   assign req.ready = (fill_ff != QUEUE_FULL);
   assign push      = req.valid && req.ready && known;

   assign cmd.valid = (fill_ff != 2'd0);
   assign cmd.op    = op_ff[rd_ptr_ff];
   assign cmd.value = value_ff[rd_ptr_ff];
   assign pop       = cmd.valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]    <= req.func;
         value_ff[wr_ptr_ff] <= req.value;
      end
   end

endmodule

// ===== hdl/ded_back.sv =====
// ----------------------------------------------------------------------------
// ded_back
// Executes queued commands against the circular entry store and drives the
// registered response channel. Pops and listings read the store through a
// registered read port.
// ----------------------------------------------------------------------------
module ded_back import ded_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   output logic      cmd_ready,
   ded_rsp_if.source rsp
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_LIST = 2'd2;

   // base < DEPTH and offs <= DEPTH, so one subtract wraps the sum
   function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                 logic [CNT_W-1:0] offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= DEPTH_SUM) sum = sum - DEPTH_SUM;
      return sum[PTR_W-1:0];
   endfunction

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic                      out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]       out_status_ff;
   logic signed [VALUE_W-1:0] out_data_ff;
   logic [CNT_W-1:0]          out_occ_ff;
   logic                      out_last_ff;

   logic                      out_free;
   logic                      is_empty;
   logic                      is_full;
   logic                      load;
   logic [STATUS_W-1:0]       ld_status;
   logic signed [VALUE_W-1:0] ld_data;
   logic                      ld_last;
   logic                      wr_en;
   logic [PTR_W-1:0]          wr_addr;
   logic                      rd_en;
   logic [PTR_W-1:0]          rd_addr;

   assign out_free = !out_valid_ff || rsp.ready;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_COUNT);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmd_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = wrap_add(head_ff, count_ff);
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      load      = 1'b0;
      ld_status = ST_OK;
      ld_data   = '0;
      ld_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd.op)
                  FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                     load = 1'b1;
                     if (is_full) begin
                        ld_status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (cmd.op == FUNC_PUSH_FRONT) begin
                           head_in = (head_ff == '0) ? LAST_PTR : head_ff - PTR_W'(1);
                           wr_addr = head_in;
                        end
                     end
                  end
                  FUNC_POP_BACK, FUNC_POP_FRONT: begin
                     if (is_empty) begin
                        load      = 1'b1;
                        ld_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_POP;
                        if (cmd.op == FUNC_POP_BACK) begin
                           rd_addr = wrap_add(head_ff, count_ff - CNT_W'(1));
                        end else begin
                           head_in = wrap_add(head_ff, CNT_W'(1));
                        end
                     end
                  end
                  FUNC_LIST: begin
                     if (is_empty) begin
                        load      = 1'b1;
                        ld_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = CNT_W'(1);
                        state_in = S_LIST;
                     end
                  end
                  FUNC_COUNT: begin
                     load = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               load     = 1'b1;
               ld_data  = rd_data_ff;
               state_in = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               load    = 1'b1;
               ld_data = rd_data_ff;
               ld_last = (idx_ff == count_ff);
               if (ld_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(head_ff, idx_ff);
                  idx_in  = idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = load || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (load) begin
         out_status_ff <= ld_status;
         out_data_ff   <= ld_data;
         out_occ_ff    <= count_in;
         out_last_ff   <= ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= cmd.value;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.data      = out_data_ff;
   assign rsp.occupancy = out_occ_ff;
   assign rsp.last      = out_last_ff;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit values in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per handshake: func (push back, push front,
//   pop back, pop front, list, count) and value. Codes 6 and 7 are taken and
//   give no response. rsp_chan returns status, data, occupancy and last.
//   A request waits in a two-entry command queue until the back end runs
//   it. Push, count and refused operations load the response register
//   straight from the idle state. Pops read the store into a register in
//   the idle state and respond from the pop state. A listing of N entries
//   reads the first entry in the idle state, then gives one entry per
//   cycle while the receiver does not stall; last marks the final one.
//   Reset empties the queue at once; stored values are not cleared.
//   When the receiver stalls, the response is held in its output register,
//   the back end waits, and req_chan keeps taking requests until the
//   command queue holds two.
// ----------------------------------------------------------------------------
module double_ended_queue_top import ded_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ded_req_if.sink   req_chan,
   ded_rsp_if.source rsp_chan
);

   cmd_type cmd;
   logic    cmd_ready;

   ded_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   ded_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp       (rsp_chan)
   );

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.occupancy <= DEPTH))
      else $error("occupancy above depth");

   a_full_at_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_FULL) |-> (rsp_chan.occupancy == DEPTH))
      else $error("full reported below depth");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_EMPTY)
         |-> (rsp_chan.occupancy == 0 && rsp_chan.last))
      else $error("empty reported with entries or not last");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_OK) |-> (rsp_chan.data == 0))
      else $error("error response carries data");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks double_ended_queue_top against a local deque predictor. Requests go
// through directed cases (empty queue, single entry, full queue behind a
// stalled output) and then random traffic that swings between filling and
// draining. Random idle on both channels varies per phase.
// ----------------------------------------------------------------------------
module tb;
   import ded_pkg::*;

   localparam int Q_DEPTH     = DEPTH_DEFAULT;
   localparam int CNT_W       = CNT_W_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_REPORTS = 10;

   // codes outside the operation set, dropped by the block
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] data;
      logic [CNT_W-1:0]          occupancy;
      logic                      last;
   } deque_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ded_req_if                  req_chan ();
   ded_rsp_if #(.CNT_W(CNT_W)) rsp_chan ();

   double_ended_queue_top #(.DEPTH(Q_DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [VALUE_W-1:0] model_store [Q_DEPTH];
   int                        model_head  = 0;
   logic [CNT_W-1:0]          model_count = '0;
   deque_rsp_type             expected_rsps [$];

   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_left;
   int mismatch_count;
   int cycle_count;

   function automatic void expect_rsp(input logic [STATUS_W-1:0] status,
                                      input logic signed [VALUE_W-1:0] data,
                                      input logic last);
      deque_rsp_type r;
      r.status    = status;
      r.data      = data;
      r.occupancy = model_count;
      r.last      = last;
      expected_rsps.push_back(r);
   endfunction

   function automatic void deque_step(input logic [FUNC_W-1:0] func,
                                      input logic signed [VALUE_W-1:0] value);
      int pos;
      case (func)
         FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
            if (model_count >= Q_DEPTH) begin
               expect_rsp(ST_FULL, '0, 1'b1);
            end else begin
               if (func == FUNC_PUSH_BACK) begin
                  pos = (model_head + model_count) % Q_DEPTH;
               end else begin
                  model_head = (model_head + Q_DEPTH - 1) % Q_DEPTH;
                  pos = model_head;
               end
               model_store[pos] = value;
               model_count++;
               expect_rsp(ST_OK, '0, 1'b1);
            end
         end
         FUNC_POP_BACK, FUNC_POP_FRONT: begin
            if (model_count == 0) begin
               expect_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               if (func == FUNC_POP_BACK) begin
                  pos = (model_head + model_count - 1) % Q_DEPTH;
               end else begin
                  pos = model_head;
                  model_head = (model_head + 1) % Q_DEPTH;
               end
               model_count--;
               expect_rsp(ST_OK, model_store[pos], 1'b1);
            end
         end
         FUNC_LIST: begin
            if (model_count == 0) begin
               expect_rsp(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < model_count; i++) begin
                  expect_rsp(ST_OK, model_store[(model_head + i) % Q_DEPTH],
                             i == model_count - 1);
               end
            end
         end
         FUNC_COUNT: begin
            expect_rsp(ST_OK, '0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   // one request; returns at the accepting edge
   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic signed [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func  <= func;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      deque_step(func, value);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_queue();
      send_request(FUNC_POP_BACK, 32'sh1234_5678);
      send_request(FUNC_POP_FRONT, '1);
      send_request(FUNC_LIST, '0);
      send_request(FUNC_COUNT, 32'sh7FFF_FFFF);
      send_request(FUNC_UNUSED_LO, 32'sh5A5A_5A5A);
      send_request(FUNC_UNUSED_HI, 32'shA5A5_A5A5);
   endtask

   task automatic test_single_entry();
      send_request(FUNC_PUSH_BACK, 32'sh7FFF_FFFF);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_PUSH_FRONT, 32'sh8000_0000);
      send_request(FUNC_POP_BACK, '0);
      send_request(FUNC_PUSH_BACK, '1);
      send_request(FUNC_LIST, '0);
      send_request(FUNC_COUNT, '0);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_PUSH_FRONT, '0);
      send_request(FUNC_POP_FRONT, '0);
   endtask

   // output held off at first, which stalls the requests; then the queue fills and overflows
   task automatic test_full_queue_stalled_output();
      rsp_hold_left = 150;
      for (int i = 0; i < Q_DEPTH; i++) begin
         send_request(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, pick_value());
      end
      send_request(FUNC_PUSH_BACK, 32'sh0BAD_F00D);
      send_request(FUNC_PUSH_FRONT, 32'sh0BAD_BEEF);
      send_request(FUNC_LIST, '0);
      send_request(FUNC_COUNT, '0);
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int n_items);
      int  sent;
      int  pick;
      int  push_pct;
      bit  filling;
      logic [FUNC_W-1:0] func;
      sent    = 0;
      filling = 1'($urandom_range(1));
      while (sent < n_items) begin
         if ($urandom_range(19) == 0) filling = !filling;
         push_pct = filling ? 60 : 25;
         pick = $urandom_range(99);
         if (pick < push_pct)
            func = $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
         else if (pick < 85)
            func = $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
         else if (pick < 93)
            func = FUNC_LIST;
         else if (pick < 97)
            func = FUNC_COUNT;
         else
            func = $urandom_range(1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
         send_request(func, pick_value());
         if (func <= FUNC_COUNT) sent++;
      end
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("tb: %s mismatch: expected %h, got %h", field, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      deque_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("tb: response with none expected, data %h", rsp_chan.data);
         end else begin
            want = expected_rsps.pop_front();
            note_mismatch("status", 32'(want.status), 32'(rsp_chan.status));
            note_mismatch("data", want.data, rsp_chan.data);
            note_mismatch("occupancy", 32'(want.occupancy), 32'(rsp_chan.occupancy));
            note_mismatch("last", 32'(want.last), 32'(rsp_chan.last));
         end
      end
   end

   initial begin : rsp_ready_driver
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func  = FUNC_COUNT;
      req_chan.value = '0;
      send_idle_pct  = 12;
      recv_idle_pct  = 68;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_single_entry();
      test_full_queue_stalled_output();
      test_random_traffic(95);
      wait_for_drain();

      send_idle_pct = 68;
      recv_idle_pct = 12;
      test_random_traffic(95);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(95);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
